@@ hw/rtl/linear_bin_histogram_top_assert.svh @@
// Assertion macros for the linear bin histogram checker.
// Bodies refer to clk_i and rst_ni of the module that uses them.
`ifndef LINEAR_BIN_HISTOGRAM_TOP_ASSERT_SVH
`define LINEAR_BIN_HISTOGRAM_TOP_ASSERT_SVH

// checked out of reset only
`define LBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define LBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/lbh_pkg.sv @@
// Shared constants, register indexes and types of the linear bin histogram.
// No dependencies.
package lbh_pkg;

  localparam int unsigned SMP_W      = 32;  // sample and range width
  localparam int unsigned NB_W       = 8;   // bins_in_use width
  localparam int unsigned RB_W       = 7;   // read_bin / bin_number width
  localparam int unsigned TOTAL_W    = 32;  // bin_total width
  localparam int unsigned PROD_W     = SMP_W + NB_W;
  localparam int unsigned DIV_CNT_W  = $clog2(NB_W);

  localparam int unsigned DEF_MAX_BINS   = 128;
  localparam int unsigned DEF_COUNT_BITS = 32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS       = 2'd2;

  localparam logic [SMP_W-1:0] RST_RANGE_LOW  = '0;
  localparam logic [SMP_W-1:0] RST_RANGE_HIGH = '1;
  localparam logic [NB_W-1:0]  RST_BINS       = 8'd100;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [SMP_W-1:0] low;
    logic [SMP_W-1:0] high;
    logic [NB_W-1:0]  nb;     // active bins, clamped to the table size and to 255
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [SMP_W-1:0] d;
    logic [NB_W-1:0]  nb;
    logic [SMP_W-1:0] span;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NB_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ hw/rtl/lbh_in_if.sv @@
// Input channel: one sample or read request per word.
// Depends on lbh_pkg.
interface lbh_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [lbh_pkg::SMP_W-1:0] sample;
  logic [lbh_pkg::RB_W-1:0]  read_bin;

  modport source (output valid, kind, sample, read_bin, input ready);
  modport sink   (input valid, kind, sample, read_bin, output ready);
endinterface

@@ hw/rtl/lbh_out_if.sv @@
// Output channel: one result word per accepted input word.
// Depends on lbh_pkg.
interface lbh_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbh_pkg::RB_W-1:0]    bin_number;
  logic [lbh_pkg::TOTAL_W-1:0] bin_total;
  logic                        rejected;

  modport source (output valid, bin_number, bin_total, rejected, input ready);
  modport sink   (input valid, bin_number, bin_total, rejected, output ready);
endinterface

@@ hw/rtl/lbh_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on lbh_pkg.
interface lbh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lbh_pkg::CFG_IDX_W-1:0]  index;
  logic [lbh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/linear_bin_histogram_top.sv @@
// Uniform-bin histogram of unsigned samples between range_low and range_high.
// Depends on lbh_pkg, the lbh_*_if interfaces, lbh_cfg, lbh_div and lbh_ram.

// After reset all MAX_BINS bin memory entries are zeroed in one pass, during
// which no input word is taken; configuration writes are taken at any time.
// One input word is worked at a time. An in-range sample has its d*bins
// product registered, takes eight quotient steps to the bin index, reads the
// memory and writes the count back as its result enters the output register;
// one at range_high skips the division. A valid read request goes straight to
// the memory read, a rejected word to the load. The next word is accepted the
// cycle after a result is loaded; the result stays until the sink takes it.
module linear_bin_histogram_top #(
  parameter int unsigned MAX_BINS   = lbh_pkg::DEF_MAX_BINS,
  parameter int unsigned COUNT_BITS = lbh_pkg::DEF_COUNT_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbh_in_if.sink    in_i,
  lbh_out_if.source out_o,
  lbh_cfg_if.sink   cfg_i
);

  localparam int unsigned AddrW = $clog2(MAX_BINS);
  localparam int unsigned SmpW  = lbh_pkg::SMP_W;
  localparam int unsigned NbW   = lbh_pkg::NB_W;
  localparam int unsigned RbW   = lbh_pkg::RB_W;
  localparam int unsigned TotW  = lbh_pkg::TOTAL_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_WB    = 3'd5;

  lbh_pkg::cfg_t     cfg;
  lbh_pkg::div_req_t div_req;
  lbh_pkg::div_rsp_t div_rsp;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;

  logic             kind_q, rej_q;
  logic [SmpW-1:0]  d_q, span_q;
  logic [NbW-1:0]   nb_q, bin_q;
  logic [RbW-1:0]   bin_number_q;
  logic [TotW-1:0]  bin_total_q;
  logic             rejected_q;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, cnt_inc;

  logic in_acc, smp_ok, rd_ok, at_high, out_free, out_load, count_wr;

  lbh_cfg #(.MAX_BINS(MAX_BINS)) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lbh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AddrW'(bin_q)),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign smp_ok     = (cfg.nb != '0) && (cfg.high > cfg.low) &&
                      (in_i.sample >= cfg.low) && (in_i.sample <= cfg.high);
  assign at_high    = (in_i.sample == cfg.high);
  assign rd_ok      = {1'b0, in_i.read_bin} < cfg.nb;

  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == ST_WB) && out_free;
  assign count_wr = out_load && !rej_q && (kind_q == lbh_pkg::KIND_ADD);
  assign cnt_inc  = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

  assign div_req.start = (state_q == ST_START);
  assign div_req.d     = d_q;
  assign div_req.nb    = nb_q;
  assign div_req.span  = span_q;

  assign ram_re = (state_q == ST_READ);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ram_we    = 1'b0;
    ram_waddr = AddrW'(bin_q);
    ram_wdata = cnt_inc;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == AddrW'(MAX_BINS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.kind == lbh_pkg::KIND_READ) begin
            state_d = rd_ok ? ST_READ : ST_WB;
          end else if (!smp_ok) begin
            state_d = ST_WB;
          end else if (at_high) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_WB;
      ST_WB: begin
        ram_we = count_wr;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= in_i.kind;
      d_q    <= in_i.sample - cfg.low;
      span_q <= cfg.high - cfg.low;
      nb_q   <= cfg.nb;
      if (in_i.kind == lbh_pkg::KIND_READ) begin
        bin_q <= NbW'(in_i.read_bin);
        rej_q <= !rd_ok;
      end else begin
        rej_q <= !smp_ok;
        bin_q <= (smp_ok && at_high) ? cfg.nb - 1'b1 : '0;
      end
    end else if ((state_q == ST_DIV) && div_rsp.done) begin
      bin_q <= (div_rsp.quo >= nb_q) ? nb_q - 1'b1 : div_rsp.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bin_number_q <= RbW'(bin_q);
      rejected_q   <= rej_q;
      if (rej_q) begin
        bin_total_q <= '0;
      end else if (kind_q == lbh_pkg::KIND_ADD) begin
        bin_total_q <= TotW'(cnt_inc);
      end else begin
        bin_total_q <= TotW'(ram_rdata);
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.bin_number = bin_number_q;
  assign out_o.bin_total  = bin_total_q;
  assign out_o.rejected   = rejected_q;

endmodule

@@ hw/rtl/lbh_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lbh_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 128,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lbh_cfg.sv @@
// Configuration registers and active bin count of the histogram.
// Depends on lbh_pkg and lbh_cfg_if.
module lbh_cfg #(
  parameter int unsigned MAX_BINS = lbh_pkg::DEF_MAX_BINS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbh_cfg_if.sink       cfg_i,
  output lbh_pkg::cfg_t cfg_o
);

  localparam int unsigned NbW   = lbh_pkg::NB_W;
  localparam int unsigned SmpW  = lbh_pkg::SMP_W;
  localparam int unsigned NbMax = (MAX_BINS > 255) ? 255 : MAX_BINS;

  logic [SmpW-1:0] low_q, high_q;
  logic [NbW-1:0]  bins_q;
  logic            wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= lbh_pkg::RST_RANGE_LOW;
      high_q <= lbh_pkg::RST_RANGE_HIGH;
      bins_q <= lbh_pkg::RST_BINS;
    end else if (wr) begin
      case (cfg_i.index)
        lbh_pkg::REG_RANGE_LOW:  low_q  <= cfg_i.data[SmpW-1:0];
        lbh_pkg::REG_RANGE_HIGH: high_q <= cfg_i.data[SmpW-1:0];
        lbh_pkg::REG_BINS:       bins_q <= cfg_i.data[NbW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.low  = low_q;
    cfg_o.high = high_q;
    cfg_o.nb   = (bins_q > NbW'(NbMax)) ? NbW'(NbMax) : bins_q;
  end

endmodule

@@ hw/rtl/lbh_div.sv @@
// Bin index unit: registered d*nb product, then one quotient bit per cycle
// against the span. Quotient is below nb, so NB_W steps suffice. Depends on lbh_pkg.
module lbh_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbh_pkg::div_req_t req_i,
  output lbh_pkg::div_rsp_t rsp_o
);

  localparam int unsigned SmpW  = lbh_pkg::SMP_W;
  localparam int unsigned NbW   = lbh_pkg::NB_W;
  localparam int unsigned ProdW = lbh_pkg::PROD_W;
  localparam int unsigned CntW  = lbh_pkg::DIV_CNT_W;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [SmpW-1:0] rem_q, span_q;
  logic [NbW-1:0]  low_q, quo_q;

  logic [ProdW-1:0] prod;
  logic [SmpW:0]    trial;
  logic             ge;
  logic [SmpW-1:0]  rem_d;

  assign prod  = ProdW'(req_i.d) * ProdW'(req_i.nb);
  assign trial = {rem_q, low_q[NbW-1]};
  assign ge    = trial >= {1'b0, span_q};

  // rem_q < span_q, so both arms fit SMP_W bits
  always_comb begin
    if (ge) begin
      rem_d = SmpW'(trial - {1'b0, span_q});
    end else begin
      rem_d = trial[SmpW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NbW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      {rem_q, low_q} <= prod;
      span_q         <= req_i.span;
      quo_q          <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[NbW-2:0], 1'b0};
      quo_q <= {quo_q[NbW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ hw/rtl/lbh_checker.sv @@
// Port-level checks of linear_bin_histogram_top, bound to every instance.
// Depends on lbh_pkg and linear_bin_histogram_top_assert.svh.
`include "linear_bin_histogram_top_assert.svh"

module lbh_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [lbh_pkg::RB_W-1:0]    bin_number_i,
  input logic [lbh_pkg::TOTAL_W-1:0] bin_total_i,
  input logic                        rejected_i
);

  // stalled result word holds
  `LBH_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(bin_number_i) && $stable(bin_total_i) && $stable(rejected_i), "result word changed under stall")

  // a refused word never reports a count
  `LBH_ASSERT(a_rej_zero, out_valid_i && rejected_i |-> bin_total_i == '0, "rejected word with nonzero total")

  // one word in flight: no back-to-back acceptance
  `LBH_ASSERT(a_one_in_flight, in_valid_i && in_ready_i |=> !in_ready_i, "input taken in consecutive cycles")

  `LBH_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_i && !in_ready_i, "handshake active in reset")

endmodule

bind linear_bin_histogram_top lbh_checker u_lbh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .bin_number_i (out_o.bin_number),
  .bin_total_i  (out_o.bin_total),
  .rejected_i   (out_o.rejected)
);

@@ verif/testbench.sv @@
// Self-checking bench for linear_bin_histogram_top: directed table, then random
// phases under several range settings and idle patterns, scored against a predictor.
// Depends on lbh_pkg, lbh_in_if, lbh_out_if, lbh_cfg_if and the histogram RTL.
module testbench;
  import lbh_pkg::*;

  localparam int unsigned BIN_SLOTS   = DEF_MAX_BINS;
  localparam int          PHASES      = 8;
  localparam int          PHASE_WORDS = 115;
  localparam int          SETTLE      = 20;
  localparam int          HOLD_LEN    = 400;
  localparam int          MAX_GAP     = 60;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          N_PROBES    = 34;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [RB_W-1:0]    bin_number;
    logic [TOTAL_W-1:0] bin_total;
    logic               rejected;
  } tally_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_op_e;
  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_e;

  typedef struct packed {
    row_op_e                op;
    logic                   kind;
    logic [SMP_W-1:0]       sample;
    logic [RB_W-1:0]        rb;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   typed;
    tally_t                 want;
  } probe_t;

  localparam tally_t FREE    = '0;
  localparam tally_t REFUSED = '{7'd0, 32'd0, 1'b1};

  // bin counts start at zero; reset range is the full sample span, 100 bins
  localparam probe_t PROBES [N_PROBES] = '{
    '{ROW_WORD, KIND_READ, 32'd0,        7'd0,   '0, 32'd0, 1'b1, '{7'd0, 32'd0, 1'b0}},
    '{ROW_WORD, KIND_READ, 32'd0,        7'd99,  '0, 32'd0, 1'b1, '{7'd99, 32'd0, 1'b0}},
    '{ROW_WORD, KIND_READ, 32'd0,        7'd100, '0, 32'd0, 1'b1, '{7'd100, 32'd0, 1'b1}},
    '{ROW_WORD, KIND_READ, 32'hFFFFFFFF, 7'd127, '0, 32'd0, 1'b1, '{7'd127, 32'd0, 1'b1}},
    '{ROW_WORD, KIND_ADD,  32'd0,        7'd127, '0, 32'd0, 1'b1, '{7'd0, 32'd1, 1'b0}},
    '{ROW_WORD, KIND_ADD,  32'hFFFFFFFF, 7'd0,   '0, 32'd0, 1'b1, '{7'd99, 32'd1, 1'b0}},
    '{ROW_WORD, KIND_ADD,  32'hFFFFFFFE, 7'd0,   '0, 32'd0, 1'b1, '{7'd99, 32'd2, 1'b0}},
    '{ROW_WORD, KIND_ADD,  32'h80000000, 7'd0,   '0, 32'd0, 1'b0, FREE},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_BINS,       32'h00000000, 1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd5,        7'd0,   '0, 32'd0, 1'b1, REFUSED},
    '{ROW_WORD, KIND_READ, 32'd0,        7'd0,   '0, 32'd0, 1'b1, REFUSED},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_BINS,       32'hABCDEFFF, 1'b0, FREE},
    '{ROW_WORD, KIND_READ, 32'd0,        7'd127, '0, 32'd0, 1'b1, '{7'd127, 32'd0, 1'b0}},
    '{ROW_WORD, KIND_ADD,  32'hFFFFFFFF, 7'd0,   '0, 32'd0, 1'b1, '{7'd127, 32'd1, 1'b0}},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_RANGE_LOW,  32'd1000,     1'b0, FREE},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_RANGE_HIGH, 32'd1000,     1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd1000,     7'd0,   '0, 32'd0, 1'b1, REFUSED},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_RANGE_HIGH, 32'd999,      1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd1000,     7'd0,   '0, 32'd0, 1'b1, REFUSED},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_RANGE_HIGH, 32'd2000,     1'b0, FREE},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_BINS,       32'd4,        1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd999,      7'd0,   '0, 32'd0, 1'b1, REFUSED},
    '{ROW_WORD, KIND_ADD,  32'd2001,     7'd0,   '0, 32'd0, 1'b1, REFUSED},
    '{ROW_WORD, KIND_ADD,  32'd1000,     7'd0,   '0, 32'd0, 1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd2000,     7'd0,   '0, 32'd0, 1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd1500,     7'd0,   '0, 32'd0, 1'b0, FREE},
    '{ROW_WORD, KIND_READ, 32'd0,        7'd4,   '0, 32'd0, 1'b1, '{7'd4, 32'd0, 1'b1}},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_SPARE,      32'h5A5A5A5A, 1'b0, FREE},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_RANGE_LOW,  32'd0,        1'b0, FREE},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_RANGE_HIGH, 32'd1,        1'b0, FREE},
    '{ROW_REG,  KIND_ADD,  32'd0, 7'd0, REG_BINS,       32'd1,        1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd0,        7'd0,   '0, 32'd0, 1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd1,        7'd0,   '0, 32'd0, 1'b0, FREE},
    '{ROW_WORD, KIND_ADD,  32'd2,        7'd0,   '0, 32'd0, 1'b1, REFUSED}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  lbh_in_if  in_if ();
  lbh_out_if out_if ();
  lbh_cfg_if cfg_if ();

  linear_bin_histogram_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #4 clk_i = ~clk_i;

  logic [SMP_W-1:0]   cur_low;
  logic [SMP_W-1:0]   cur_high;
  logic [NB_W-1:0]    cur_bins;
  logic [TOTAL_W-1:0] hist_counts [BIN_SLOTS];

  tally_t tally_q [$];
  idle_e  idle_mode = IDLE_NONE;
  int     mismatches = 0;
  int     hold_asked = 0;
  int     cycles = 0;

  function automatic longint unsigned live_bins();
    return (cur_bins > BIN_SLOTS) ? BIN_SLOTS : cur_bins;
  endfunction

  // expected result of one word; updates the predicted bin counts
  function automatic tally_t tally_word(logic kind, logic [SMP_W-1:0] smp,
                                        logic [RB_W-1:0] rb);
    tally_t            r;
    longint unsigned   nb;
    longint unsigned   span;
    longint unsigned   d;
    longint unsigned   bin;
    r  = REFUSED;
    nb = live_bins();
    if (kind == KIND_ADD) begin
      if (nb != 0 && cur_high > cur_low && smp >= cur_low && smp <= cur_high) begin
        span = cur_high - cur_low;
        d    = smp - cur_low;
        bin  = (d == span) ? nb - 1 : (d * nb) / span;
        if (bin >= nb) bin = nb - 1;
        if (hist_counts[bin] != '1) hist_counts[bin] = hist_counts[bin] + 1'b1;
        r.bin_number = bin[RB_W-1:0];
        r.bin_total  = hist_counts[bin];
        r.rejected   = 1'b0;
      end
    end else begin
      r.bin_number = rb;
      if (rb < nb) begin
        r.bin_total = hist_counts[rb];
        r.rejected  = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic int src_gap();
    int pct;
    int n;
    pct = (idle_mode == IDLE_SRC) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    n   = 0;
    while (n < MAX_GAP && $urandom_range(99, 0) < pct) n++;
    return n;
  endfunction

  task automatic send_word(input logic kind, input logic [SMP_W-1:0] smp,
                           input logic [RB_W-1:0] rb, input logic typed,
                           input tally_t want);
    int     gap;
    tally_t guess;
    gap = src_gap();
    @(negedge clk_i);
    repeat (gap) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    = 1'b1;
    in_if.kind     = kind;
    in_if.sample   = smp;
    in_if.read_bin = rb;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    guess = tally_word(kind, smp, rb);
    tally_q.push_back(typed ? want : guess);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_RANGE_LOW:  cur_low  = data[SMP_W-1:0];
      REG_RANGE_HIGH: cur_high = data[SMP_W-1:0];
      REG_BINS:       cur_bins = data[NB_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_random_word();
    longint unsigned  nb;
    longint unsigned  span;
    logic [SMP_W-1:0] smp;
    logic [RB_W-1:0]  rb;
    logic             kind;
    int               roll;
    nb   = live_bins();
    smp  = $urandom;
    rb   = $urandom_range(127, 0);
    kind = KIND_ADD;
    roll = $urandom_range(99, 0);
    if (roll < 25) begin
      kind = KIND_READ;
      if (nb != 0 && $urandom_range(3, 0) != 0) rb = $urandom_range(nb - 1, 0);
    end else if (roll < 30) begin
      smp = cur_low;
    end else if (roll < 35) begin
      smp = cur_high;
    end else if (roll < 38) begin
      if (cur_low != '0) smp = cur_low - 1'b1;
    end else if (roll < 41) begin
      if (cur_high != '1) smp = cur_high + 1'b1;
    end else if (roll < 48) begin
      smp = $urandom;
    end else if (cur_high > cur_low) begin
      span = cur_high - cur_low;
      smp  = cur_low + ({$urandom, $urandom} % (span + 1));
    end
    send_word(kind, smp, rb, 1'b0, FREE);
  endtask

  // receiver: random stalls plus requested long hold-offs
  int hold_left  = 0;
  int hold_given = 0;
  always @(negedge clk_i) begin : sink_side
    int pct;
    pct = (idle_mode == IDLE_SNK) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    if (hold_left == 0 && hold_given != hold_asked) begin
      hold_left  = HOLD_LEN;
      hold_given = hold_given + 1;
    end
    if (hold_left != 0) begin
      hold_left    = hold_left - 1;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = ($urandom_range(99, 0) >= pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    tally_t got;
    tally_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.bin_number, out_if.bin_total, out_if.rejected};
      if (tally_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: bin %0d total %0d rej %0b",
                   got.bin_number, got.bin_total, got.rejected);
        mismatches++;
      end else begin
        want = tally_q.pop_front();
        if (got.bin_number !== want.bin_number || got.bin_total !== want.bin_total ||
            got.rejected !== want.rejected) begin
          if (mismatches < 10)
            $display("mismatch: exp bin %0d total %0d rej %0b, got bin %0d total %0d rej %0b",
                     want.bin_number, want.bin_total, want.rejected,
                     got.bin_number, got.bin_total, got.rejected);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     nb;
    logic [31:0]     noise;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_ADD;
    in_if.sample   = '0;
    in_if.read_bin = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_RANGE_LOW;
    cfg_if.data    = '0;
    out_if.ready   = 1'b0;
    cur_low        = RST_RANGE_LOW;
    cur_high       = RST_RANGE_HIGH;
    cur_bins       = RST_BINS;
    foreach (hist_counts[i]) hist_counts[i] = '0;
    // falling reset edge after time zero so every process sees it
    #1 rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (PROBES[i]) begin
      if (PROBES[i].op == ROW_REG) begin
        settle();
        write_reg(PROBES[i].idx, PROBES[i].data);
      end else begin
        send_word(PROBES[i].kind, PROBES[i].sample, PROBES[i].rb,
                  PROBES[i].typed, PROBES[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      nb = $urandom_range(128, 1);
      case (ph)
        0: begin lo = 0; hi = 32'hFFFFFFFF; nb = 128; end
        1: begin lo = $urandom; hi = lo + 1 + $urandom_range(400, 0); end
        2: begin lo = 32'hFFFFFF00 + $urandom_range(127, 0); hi = 32'hFFFFFFFF; end
        3: begin
          lo = $urandom_range(32'h7FFFFFFF, 0);
          hi = lo + 1 + $urandom_range(32'h7FFFFFFE, 0);
          nb = $urandom_range(255, 129);
        end
        4: begin lo = 0; hi = 127; nb = 128; end
        5: begin lo = $urandom_range(32'hFFFF0000, 0); hi = lo + 1 + $urandom_range(32'hFFFE, 0); end
        6: begin lo = $urandom_range(32'hFFFFFFF0, 0); hi = lo + $urandom_range(3, 1); end
        default: begin lo = $urandom_range(1000, 0); hi = lo + $urandom_range(100000, 1); nb = 1; end
      endcase
      if (hi > 32'hFFFFFFFF) hi = 32'hFFFFFFFF;
      if (lo >= hi) lo = hi - 1;
      noise = $urandom;
      write_reg(REG_RANGE_LOW, lo[31:0]);
      write_reg(REG_RANGE_HIGH, hi[31:0]);
      write_reg(REG_BINS, {noise[31:8], nb[7:0]});
      idle_mode = idle_e'(ph % 4);
      if (ph == 0 || ph == 5) hold_asked++;
      repeat (PHASE_WORDS) send_random_word();
    end

    settle();
    if (mismatches == 0 && tally_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ linear_bin_histogram_top.f @@
+incdir+hw/rtl
hw/rtl/lbh_pkg.sv
hw/rtl/lbh_in_if.sv
hw/rtl/lbh_out_if.sv
hw/rtl/lbh_cfg_if.sv
hw/rtl/lbh_ram.sv
hw/rtl/lbh_cfg.sv
hw/rtl/lbh_div.sv
hw/rtl/linear_bin_histogram_top.sv
hw/rtl/lbh_checker.sv
verif/testbench.sv
